### rtl/battery_monitor_soc_fsm_macros.svh
// Assertion macros shared by the battery monitor checker.
`ifndef BATTERY_MONITOR_SOC_FSM_MACROS_SVH
`define BATTERY_MONITOR_SOC_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery monitor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery monitor assertion failed");

`endif

### rtl/bmsf_pkg.sv
// Shared constants and types of the battery monitor.
package bmsf_pkg;

    localparam int SUM_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int SPW_W     = 9;
    localparam int SCALE_W   = 20;
    localparam int MV_W      = 16;
    localparam int SOC_W     = 16;
    localparam int MODE_W    = 2;
    localparam int NUM_CH    = 5;
    localparam int CH_W      = 3;
    localparam int Q_SHIFT   = 16;
    localparam int PROD_W    = SUM_W + SCALE_W;

    localparam int DEF_ADC_BITS   = 12;
    localparam int DEF_MAX_WINDOW = 256;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ON       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAT_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAT_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LDO       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_START = 3'd7;

    localparam logic [CH_W-1:0] CH_BAT  = 3'd0;
    localparam logic [CH_W-1:0] CH_LOAD = 3'd1;
    localparam logic [CH_W-1:0] CH_CHG  = 3'd2;
    localparam logic [CH_W-1:0] CH_BMA  = 3'd3;
    localparam logic [CH_W-1:0] CH_LMA  = 3'd4;

    localparam logic [SPW_W-1:0]   RST_SPW       = 9'd5;
    localparam logic [SCALE_W-1:0] RST_VOLT      = 20'd65536;
    localparam logic [SCALE_W-1:0] RST_AMP       = 20'd65536;
    localparam logic [MV_W-1:0]    RST_BAT_MIN   = 16'd3000;
    localparam logic [MV_W-1:0]    RST_BAT_MAX   = 16'd4200;
    localparam logic [MV_W-1:0]    RST_LDO       = 16'd3300;
    localparam logic [SCALE_W-1:0] RST_SOC_GAIN  = 20'd256;
    localparam logic [SOC_W-1:0]   RST_SOC_START = 16'd25600;

    localparam logic [SOC_W-1:0] SOC_FULL = 16'd25600;
    localparam logic [MV_W-1:0]  MV_SAT   = 16'hFFFF;

    typedef struct packed {
        logic [MV_W-1:0]   bat;
        logic [MV_W-1:0]   load;
        logic [MV_W-1:0]   chg;
        logic [SUM_W-1:0]  delta;
        logic [SOC_W-1:0]  soc;
        logic [MODE_W-1:0] mode;
        logic              reg_en;
        logic              done;
        logic [MV_W-1:0]   bat_min;
        logic [MV_W-1:0]   bat_max;
        logic [MV_W-1:0]   ldo;
    } step_in_t;

    typedef struct packed {
        logic [SOC_W-1:0]  soc;
        logic [SOC_W-1:0]  report;
        logic [MODE_W-1:0] mode;
        logic              reg_en;
    } step_out_t;

endpackage

### rtl/bmsf_div.sv
// Restoring serial divider: one quotient bit per cycle.
module bmsf_div #(
    parameter int DEN_W = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bmsf_pkg::SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]           divisor,
    output logic                       busy,
    output logic [bmsf_pkg::SUM_W-1:0] quotient
);
    import bmsf_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W:0]    rem_shift;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[SUM_W-1]};
        diff      = rem_shift - {1'b0, divisor};
        fits      = rem_shift >= {1'b0, divisor};
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            step_next = STEP_W'(SUM_W);
            rem_next  = '0;
            quot_next = dividend;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            // The partial remainder stays below the divisor, so it fits DEN_W bits.
            rem_next  = fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quot_next = {quot_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy     = step_reg != '0;
    assign quotient = quot_reg;

endmodule

### rtl/bmsf_mode_step.sv
// Mode machine rules and state-of-charge calibration for one window.
module bmsf_mode_step (
    input  bmsf_pkg::step_in_t  step_in,
    output bmsf_pkg::step_out_t step_out
);
    import bmsf_pkg::*;

    logic [SOC_W:0]    soc_sum;
    logic [SOC_W-1:0]  soc_m;
    logic [SOC_W-1:0]  report;
    logic [MODE_W-1:0] mode_m;
    logic              en_m;
    logic              chg_hi;
    logic              bat_ok;

    always_comb
    begin
        soc_m   = step_in.soc;
        mode_m  = step_in.mode;
        en_m    = step_in.reg_en;
        chg_hi  = step_in.chg >= step_in.bat_max;
        bat_ok  = step_in.bat >= step_in.bat_min;
        soc_sum = {1'b0, step_in.soc} + (SOC_W+1)'(step_in.delta);

        // Rules are evaluated in order; a later rule overrides an earlier one.
        case (step_in.mode)
            MODE_CHARGING:
            begin
                if (!step_in.done && chg_hi)
                begin
                    soc_m = (soc_sum > (SOC_W+1)'(MV_SAT) || step_in.delta[SUM_W-1:SOC_W] != '0)
                          ? MV_SAT : soc_sum[SOC_W-1:0];
                end
                if (step_in.load < step_in.ldo && !chg_hi && step_in.done)
                begin
                    mode_m = MODE_IDLE;
                end
                if (bat_ok)
                begin
                    en_m   = 1'b1;
                    mode_m = MODE_ON;
                end
            end
            MODE_ON:
            begin
                if (step_in.bat <= step_in.bat_min)
                begin
                    en_m   = 1'b0;
                    mode_m = MODE_CHARGING;
                end
                if (bat_ok && step_in.load >= step_in.ldo)
                begin
                    mode_m = MODE_ON;
                    soc_m  = (step_in.delta >= SUM_W'(step_in.soc))
                           ? '0 : step_in.soc - step_in.delta[SOC_W-1:0];
                end
                if (chg_hi && !step_in.done)
                begin
                    mode_m = MODE_CHARGING;
                end
                if (bat_ok && !chg_hi && step_in.load < step_in.ldo)
                begin
                    mode_m = MODE_IDLE;
                end
            end
            default:
            begin
                mode_m = MODE_IDLE;
                if ((step_in.bat < step_in.bat_max || !step_in.done) && chg_hi)
                begin
                    mode_m = MODE_CHARGING;
                end
                if (bat_ok)
                begin
                    en_m   = 1'b1;
                    mode_m = MODE_ON;
                end
            end
        endcase

        // Full calibration shows up only from the next window on.
        report = soc_m;
        if (step_in.done && step_in.bat >= step_in.bat_max)
        begin
            soc_m = SOC_FULL;
        end
        if (!bat_ok)
        begin
            soc_m  = '0;
            report = '0;
        end

        step_out.soc    = soc_m;
        step_out.report = report;
        step_out.mode   = mode_m;
        step_out.reg_en = en_m;
    end

endmodule

### rtl/battery_monitor_soc_fsm.sv
// Top level of the battery monitor with coulomb-counting state of charge.
// A tick that does not close a window is absorbed and leaves the block idle, ready
// for the next tick. A tick that closes a window occupies the block: each of the
// five channel sums goes through a shared 20-step serial divider, loaded in
// ST_LOAD, and then through one shared 20x20 multiplier, with the product
// registered in ST_MUL and saturated in ST_SAT, followed by one multiply for the
// charge delta and the mode step; the serial divider takes most of that time.
// The finished result sits in an output register, so the next tick is taken
// while it waits; only the mode step waits for that register to free up.
module battery_monitor_soc_fsm #(
    parameter int ADC_BITS   = bmsf_pkg::DEF_ADC_BITS,
    parameter int MAX_WINDOW = bmsf_pkg::DEF_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmsf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ADC_BITS-1:0]            bat_raw,
    input  logic [ADC_BITS-1:0]            load_raw,
    input  logic [ADC_BITS-1:0]            charger_raw,
    input  logic [ADC_BITS-1:0]            bat_current_raw,
    input  logic [ADC_BITS-1:0]            load_current_raw,
    input  logic                           charger_done,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bmsf_pkg::MV_W-1:0]      bat_mv,
    output logic [bmsf_pkg::MV_W-1:0]      load_mv,
    output logic [bmsf_pkg::MV_W-1:0]      charger_mv,
    output logic [bmsf_pkg::MV_W-1:0]      bat_ma,
    output logic [bmsf_pkg::MV_W-1:0]      load_ma,
    output logic [bmsf_pkg::SOC_W-1:0]     soc_report,
    output logic [bmsf_pkg::MODE_W-1:0]    mode,
    output logic                           regulator_on
);
    import bmsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_SAT   = 7'b0010000,
        ST_DELTA = 7'b0100000,
        ST_STEP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SPW_W-1:0]   spw_reg;
    logic [SCALE_W-1:0] volt_scale_reg;
    logic [SCALE_W-1:0] amp_scale_reg;
    logic [MV_W-1:0]    bat_min_reg;
    logic [MV_W-1:0]    bat_max_reg;
    logic [MV_W-1:0]    ldo_reg;
    logic [SCALE_W-1:0] soc_gain_reg;

    logic [SUM_W-1:0]  sums_reg [NUM_CH];
    logic [SUM_W-1:0]  sums_next [NUM_CH];
    logic [SUM_W-1:0]  samples [NUM_CH];
    logic [SUM_W:0]    sum_add;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  win;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [SUM_W-1:0]  avg_reg, avg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MV_W-1:0]   res_reg [NUM_CH];
    logic [MV_W-1:0]   res_next [NUM_CH];
    logic              done_reg, done_next;
    logic [SOC_W-1:0]  soc_reg, soc_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              reg_en_reg, reg_en_next;

    logic              out_valid_reg, out_valid_next;
    logic [MV_W-1:0]   out_res_reg [NUM_CH];
    logic [MV_W-1:0]   out_res_next [NUM_CH];
    logic [SOC_W-1:0]  out_soc_reg, out_soc_next;
    logic [MODE_W-1:0] out_mode_reg, out_mode_next;
    logic              out_en_reg, out_en_next;

    logic              in_acc;
    logic              win_end;
    logic              div_start;
    logic              div_busy;
    logic [SUM_W-1:0]  div_quot;
    logic [SUM_W-1:0]  mul_a;
    logic [SCALE_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [MV_W-1:0]   ma_sel;
    logic [PROD_W-Q_SHIFT-1:0] prod_hi;
    logic [MV_W-1:0]   prod_sat;
    step_in_t          step_in;
    step_out_t         step_out;

    assign samples[CH_BAT]  = SUM_W'(bat_raw);
    assign samples[CH_LOAD] = SUM_W'(load_raw);
    assign samples[CH_CHG]  = SUM_W'(charger_raw);
    assign samples[CH_BMA]  = SUM_W'(bat_current_raw);
    assign samples[CH_LMA]  = SUM_W'(load_current_raw);

    // A window of zero acts as one; anything above the maximum acts as the maximum.
    always_comb
    begin
        if (spw_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (32'(spw_reg) > 32'(MAX_WINDOW))
        begin
            win = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win = CNT_W'(spw_reg);
        end
    end

    assign cnt_inc  = cnt_reg + 1'b1;
    assign win_end  = cnt_inc >= win;
    assign in_stall = state_reg != ST_IDLE;
    assign in_acc   = in_valid && !in_stall;

    // Shared multiplier: channel scaling, or the charge delta in its own step.
    assign ma_sel   = (mode_reg == MODE_ON) ? res_reg[CH_LMA] : res_reg[CH_BMA];
    assign mul_a    = (state_reg == ST_DELTA) ? SUM_W'(ma_sel) : avg_reg;
    assign mul_b    = (state_reg == ST_DELTA) ? soc_gain_reg
                    : ((ch_reg >= CH_BMA) ? amp_scale_reg : volt_scale_reg);
    assign mul_p    = mul_a * mul_b;
    assign prod_hi  = prod_reg[PROD_W-1:Q_SHIFT];
    assign prod_sat = (prod_hi[PROD_W-Q_SHIFT-1:MV_W] != '0) ? MV_SAT : prod_hi[MV_W-1:0];

    bmsf_div #(
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sums_reg[ch_reg]),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_comb
    begin
        step_in.bat     = res_reg[CH_BAT];
        step_in.load    = res_reg[CH_LOAD];
        step_in.chg     = res_reg[CH_CHG];
        step_in.delta   = prod_reg[Q_SHIFT+SUM_W-1:Q_SHIFT];
        step_in.soc     = soc_reg;
        step_in.mode    = mode_reg;
        step_in.reg_en  = reg_en_reg;
        step_in.done    = done_reg;
        step_in.bat_min = bat_min_reg;
        step_in.bat_max = bat_max_reg;
        step_in.ldo     = ldo_reg;
    end

    bmsf_mode_step u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        sums_next      = sums_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        avg_next       = avg_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        done_next      = done_reg;
        soc_next       = soc_reg;
        mode_next      = mode_reg;
        reg_en_next    = reg_en_reg;
        out_res_next   = out_res_reg;
        out_soc_next   = out_soc_reg;
        out_mode_next  = out_mode_reg;
        out_en_next    = out_en_reg;
        div_start      = 1'b0;
        sum_add        = '0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        sum_add      = {1'b0, sums_reg[i]} + {1'b0, samples[i]};
                        sums_next[i] = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    end
                    done_next = charger_done;
                    cnt_next  = cnt_inc;
                    if (win_end)
                    begin
                        ch_next    = CH_BAT;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    avg_next   = div_quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                res_next[ch_reg] = prod_sat;
                if (ch_reg == CH_LMA)
                begin
                    state_next = ST_DELTA;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DELTA:
            begin
                prod_next  = mul_p;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // The step commits only once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    soc_next       = step_out.soc;
                    mode_next      = step_out.mode;
                    reg_en_next    = step_out.reg_en;
                    out_res_next   = res_reg;
                    out_soc_next   = step_out.report;
                    out_mode_next  = step_out.mode;
                    out_en_next    = step_out.reg_en;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        sums_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Writing the start register also loads the state of charge.
        if (cfg_we && cfg_index == REG_SOC_START)
        begin
            soc_next = cfg_data[SOC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spw_reg        <= RST_SPW;
            volt_scale_reg <= RST_VOLT;
            amp_scale_reg  <= RST_AMP;
            bat_min_reg    <= RST_BAT_MIN;
            bat_max_reg    <= RST_BAT_MAX;
            ldo_reg        <= RST_LDO;
            soc_gain_reg   <= RST_SOC_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPW:       spw_reg        <= cfg_data[SPW_W-1:0];
                REG_VOLT:      volt_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_AMP:       amp_scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_BAT_MIN:   bat_min_reg    <= cfg_data[MV_W-1:0];
                REG_BAT_MAX:   bat_max_reg    <= cfg_data[MV_W-1:0];
                REG_LDO:       ldo_reg        <= cfg_data[MV_W-1:0];
                REG_SOC_GAIN:  soc_gain_reg   <= cfg_data[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ch_reg        <= CH_BAT;
            soc_reg       <= RST_SOC_START;
            mode_reg      <= MODE_IDLE;
            reg_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            soc_reg       <= soc_next;
            mode_reg      <= mode_next;
            reg_en_reg    <= reg_en_next;
            out_valid_reg <= out_valid_next;
            sums_reg      <= sums_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        done_reg     <= done_next;
        out_res_reg  <= out_res_next;
        out_soc_reg  <= out_soc_next;
        out_mode_reg <= out_mode_next;
        out_en_reg   <= out_en_next;
    end

    assign out_valid    = out_valid_reg;
    assign bat_mv       = out_res_reg[CH_BAT];
    assign load_mv      = out_res_reg[CH_LOAD];
    assign charger_mv   = out_res_reg[CH_CHG];
    assign bat_ma       = out_res_reg[CH_BMA];
    assign load_ma      = out_res_reg[CH_LMA];
    assign soc_report   = out_soc_reg;
    assign mode         = out_mode_reg;
    assign regulator_on = out_en_reg;

endmodule

### rtl/bmsf_checker.sv
// Port-level checker for the battery monitor, bound to the top level.
`include "battery_monitor_soc_fsm_macros.svh"

module bmsf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [bmsf_pkg::SOC_W-1:0] soc_report,
    input logic [bmsf_pkg::MODE_W-1:0] mode
);
    import bmsf_pkg::*;

    // A stalled result stays offered, with its state of charge and mode unchanged.
    `BMSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `BMSF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(soc_report) && $stable(mode))

    // While the block is idle, a taken result leaves the output empty.
    `BMSF_ASSERT_NEXT(a_no_repeat, clk, rst_n, out_valid && !out_stall && !in_stall, !out_valid)

    // A new result is only raised from the busy final step of a window.
    `BMSF_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind battery_monitor_soc_fsm bmsf_checker u_bmsf_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the battery monitor with coulomb-counting state of charge.
module testbench;
    import bmsf_pkg::*;

    localparam int ADC_W         = DEF_ADC_BITS;
    localparam int ADC_TOP       = (1 << ADC_W) - 1;
    localparam int SUM_CEIL      = (1 << SUM_W) - 1;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [ADC_W-1:0] bat;
        logic [ADC_W-1:0] load;
        logic [ADC_W-1:0] chg;
        logic [ADC_W-1:0] bcur;
        logic [ADC_W-1:0] lcur;
        logic             done;
    } tick_t;

    typedef struct packed {
        logic [MV_W-1:0]   bat_mv;
        logic [MV_W-1:0]   load_mv;
        logic [MV_W-1:0]   chg_mv;
        logic [MV_W-1:0]   bat_ma;
        logic [MV_W-1:0]   load_ma;
        logic [SOC_W-1:0]  soc;
        logic [MODE_W-1:0] mode;
        logic              reg_on;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ADC_W-1:0]     bat_raw = '0;
    logic [ADC_W-1:0]     load_raw = '0;
    logic [ADC_W-1:0]     charger_raw = '0;
    logic [ADC_W-1:0]     bat_current_raw = '0;
    logic [ADC_W-1:0]     load_current_raw = '0;
    logic                 charger_done = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MV_W-1:0]      bat_mv;
    logic [MV_W-1:0]      load_mv;
    logic [MV_W-1:0]      charger_mv;
    logic [MV_W-1:0]      bat_ma;
    logic [MV_W-1:0]      load_ma;
    logic [SOC_W-1:0]     soc_report;
    logic [MODE_W-1:0]    mode;
    logic                 regulator_on;

    battery_monitor_soc_fsm i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .bat_raw          (bat_raw),
        .load_raw         (load_raw),
        .charger_raw      (charger_raw),
        .bat_current_raw  (bat_current_raw),
        .load_current_raw (load_current_raw),
        .charger_done     (charger_done),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bat_mv           (bat_mv),
        .load_mv          (load_mv),
        .charger_mv       (charger_mv),
        .bat_ma           (bat_ma),
        .load_ma          (load_ma),
        .soc_report       (soc_report),
        .mode             (mode),
        .regulator_on     (regulator_on)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gauge settings as the block should hold them.
    logic [SPW_W-1:0]   g_spw       = RST_SPW;
    logic [SCALE_W-1:0] g_volt      = RST_VOLT;
    logic [SCALE_W-1:0] g_amp       = RST_AMP;
    logic [MV_W-1:0]    g_bat_min   = RST_BAT_MIN;
    logic [MV_W-1:0]    g_bat_max   = RST_BAT_MAX;
    logic [MV_W-1:0]    g_ldo       = RST_LDO;
    logic [SCALE_W-1:0] g_soc_gain  = RST_SOC_GAIN;
    logic [SOC_W-1:0]   g_soc_start = RST_SOC_START;

    // Gauge state as the block should hold it.
    int unsigned        chan_sum [NUM_CH] = '{default: 0};
    int unsigned        tick_cnt = 0;
    logic [SOC_W-1:0]   soc_now = RST_SOC_START;
    logic [MODE_W-1:0]  mode_now = MODE_IDLE;
    logic               reg_en_now = 1'b0;

    tick_t       tick_queue [$];
    reading_t    pending_readings [$];
    int unsigned ticks_in_flight = 0;
    int unsigned mismatch_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    logic [ADC_W-1:0] op_pt [NUM_CH];
    logic        op_done;

    function automatic int unsigned scaled_reading(input int unsigned avg,
                                                   input logic [SCALE_W-1:0] k);
        longint unsigned a;
        longint unsigned p;
        a = avg;
        p = (a * k) >> Q_SHIFT;
        return (p > 65535) ? 65535 : int'(p);
    endfunction

    function automatic int unsigned charge_delta(input logic [MV_W-1:0] ma);
        longint unsigned a;
        a = ma;
        return int'((a * g_soc_gain) >> Q_SHIFT);
    endfunction

    // Accumulates one tick; at a window end works out the reading the block must emit.
    function automatic void gauge_predict_tick(input tick_t t);
        int unsigned     raw [NUM_CH];
        int unsigned     s;
        int unsigned     d;
        int unsigned     win;
        logic [MV_W-1:0] v [NUM_CH];
        logic [MV_W-1:0] bat;
        logic [MV_W-1:0] load;
        logic [MV_W-1:0] chg;
        reading_t        r;
        raw[CH_BAT]  = t.bat;
        raw[CH_LOAD] = t.load;
        raw[CH_CHG]  = t.chg;
        raw[CH_BMA]  = t.bcur;
        raw[CH_LMA]  = t.lcur;
        for (int i = 0; i < NUM_CH; i++)
        begin
            s = chan_sum[i] + raw[i];
            chan_sum[i] = (s > SUM_CEIL) ? SUM_CEIL : s;
        end
        tick_cnt++;
        win = g_spw;
        if (win == 0)
            win = 1;
        if (win > DEF_MAX_WINDOW)
            win = DEF_MAX_WINDOW;
        if (tick_cnt < win)
            return;

        for (int i = 0; i < NUM_CH; i++)
        begin
            v[i] = MV_W'(scaled_reading(chan_sum[i] / tick_cnt, (i < 3) ? g_volt : g_amp));
            chan_sum[i] = 0;
        end
        tick_cnt = 0;
        bat  = v[CH_BAT];
        load = v[CH_LOAD];
        chg  = v[CH_CHG];

        // Rules are applied in order, so a later rule overrides an earlier one.
        case (mode_now)
            MODE_CHARGING:
            begin
                if (!t.done && chg >= g_bat_max)
                begin
                    s = soc_now + charge_delta(v[CH_BMA]);
                    soc_now = (s > 65535) ? 16'hFFFF : s[SOC_W-1:0];
                end
                if (load < g_ldo && chg < g_bat_max && t.done)
                    mode_now = MODE_IDLE;
                if (bat >= g_bat_min)
                begin
                    reg_en_now = 1'b1;
                    mode_now = MODE_ON;
                end
            end
            MODE_ON:
            begin
                if (bat <= g_bat_min)
                begin
                    reg_en_now = 1'b0;
                    mode_now = MODE_CHARGING;
                end
                if (bat >= g_bat_min && load >= g_ldo)
                begin
                    mode_now = MODE_ON;
                    d = charge_delta(v[CH_LMA]);
                    soc_now = (d >= soc_now) ? '0 : soc_now - d[SOC_W-1:0];
                end
                if (chg >= g_bat_max && !t.done)
                    mode_now = MODE_CHARGING;
                if (bat >= g_bat_min && chg < g_bat_max && load < g_ldo)
                    mode_now = MODE_IDLE;
            end
            default:
            begin
                mode_now = MODE_IDLE;
                if ((bat < g_bat_max || !t.done) && chg >= g_bat_max)
                    mode_now = MODE_CHARGING;
                if (bat >= g_bat_min)
                begin
                    reg_en_now = 1'b1;
                    mode_now = MODE_ON;
                end
            end
        endcase

        // Full calibration shows up only in the next window; empty shows up at once.
        r.soc = soc_now;
        if (t.done && bat >= g_bat_max)
            soc_now = SOC_FULL;
        if (bat < g_bat_min)
        begin
            soc_now = '0;
            r.soc = '0;
        end
        r.bat_mv  = bat;
        r.load_mv = load;
        r.chg_mv  = chg;
        r.bat_ma  = v[CH_BMA];
        r.load_ma = v[CH_LMA];
        r.mode    = mode_now;
        r.reg_on  = reg_en_now;
        pending_readings.push_back(r);
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Driver: one item per handshake, payload held while stalled.
    tick_t       cur_tick;
    int unsigned tx_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                gauge_predict_tick(cur_tick);
                ticks_in_flight--;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    cur_tick = tick_queue.pop_front();
                    bat_raw          <= cur_tick.bat;
                    load_raw         <= cur_tick.load;
                    charger_raw      <= cur_tick.chg;
                    bat_current_raw  <= cur_tick.bcur;
                    load_current_raw <= cur_tick.lcur;
                    charger_done     <= cur_tick.done;
                    in_valid         <= 1'b1;
                    tx_gap = tx_steady ? 0 : idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [MV_W-1:0] want,
                               input logic [MV_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: compares each accepted reading with the oldest prediction.
    reading_t    want_rd;
    int unsigned rx_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t reading with none expected: bat_mv %0d soc %0d mode %0d",
                             $time, bat_mv, soc_report, mode);
                    mismatch_count++;
                end
                else
                begin
                    want_rd = pending_readings.pop_front();
                    check_field("bat_mv", want_rd.bat_mv, bat_mv);
                    check_field("load_mv", want_rd.load_mv, load_mv);
                    check_field("charger_mv", want_rd.chg_mv, charger_mv);
                    check_field("bat_ma", want_rd.bat_ma, bat_ma);
                    check_field("load_ma", want_rd.load_ma, load_ma);
                    check_field("soc_report", want_rd.soc, soc_report);
                    check_field("mode", 16'(want_rd.mode), 16'(mode));
                    check_field("regulator_on", 16'(want_rd.reg_on), 16'(regulator_on));
                end
            end
            if (rx_gap != 0)
            begin
                out_stall <= 1'b1;
                rx_gap--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!rx_steady && $urandom_range(0, 5) == 0)
                    rx_gap = idle_len();
            end
        end
    end

    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        case (idx)
            REG_SPW:       g_spw      = val[SPW_W-1:0];
            REG_VOLT:      g_volt     = val[SCALE_W-1:0];
            REG_AMP:       g_amp      = val[SCALE_W-1:0];
            REG_BAT_MIN:   g_bat_min  = val[MV_W-1:0];
            REG_BAT_MAX:   g_bat_max  = val[MV_W-1:0];
            REG_LDO:       g_ldo      = val[MV_W-1:0];
            REG_SOC_GAIN:  g_soc_gain = val[SCALE_W-1:0];
            REG_SOC_START:
            begin
                // Writing the start value also reloads the state of charge.
                g_soc_start = val[SOC_W-1:0];
                soc_now     = val[SOC_W-1:0];
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (ticks_in_flight != 0 || pending_readings.size() != 0)
            @(posedge clk);
        // A tick that ends no window leaves the block idle, with its sums kept for the window.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_tick(input int unsigned b, input int unsigned l, input int unsigned c,
                              input int unsigned bi, input int unsigned li, input bit d);
        tick_t t;
        t.bat  = b[ADC_W-1:0];
        t.load = l[ADC_W-1:0];
        t.chg  = c[ADC_W-1:0];
        t.bcur = bi[ADC_W-1:0];
        t.lcur = li[ADC_W-1:0];
        t.done = d;
        tick_queue.push_back(t);
        ticks_in_flight++;
    endtask

    function automatic int unsigned clamp_adc(input longint r);
        if (r < 0)
            return 0;
        if (r > ADC_TOP)
            return ADC_TOP;
        return int'(r);
    endfunction

    // Raw count that lands near a millivolt threshold at the current scale.
    function automatic int unsigned raw_near(input logic [MV_W-1:0] mv);
        longint r;
        if (g_volt == 0)
            return $urandom_range(0, ADC_TOP);
        r = (longint'(mv) <<< Q_SHIFT) / longint'(g_volt);
        return clamp_adc(r + longint'($urandom_range(0, 4)) - 2);
    endfunction

    function automatic int unsigned volt_pick();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return ADC_TOP;
            2, 3:    return raw_near(g_bat_min);
            4, 5:    return raw_near(g_bat_max);
            6:       return raw_near(g_ldo);
            default: return $urandom_range(0, ADC_TOP);
        endcase
    endfunction

    function automatic int unsigned amp_pick();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return ADC_TOP;
            2:       return $urandom_range(0, 40);
            default: return $urandom_range(0, ADC_TOP);
        endcase
    endfunction

    function automatic int unsigned jitter(input logic [ADC_W-1:0] v);
        return clamp_adc(longint'(v) + longint'($urandom_range(0, 6)) - 3);
    endfunction

    task automatic move_operating_point(input int ch);
        case (ch)
            CH_BAT, CH_LOAD, CH_CHG: op_pt[ch] = ADC_W'(volt_pick());
            CH_BMA, CH_LMA:          op_pt[ch] = ADC_W'(amp_pick());
            default:                 op_done = 1'($urandom_range(0, 1));
        endcase
    endtask

    // Ticks hover around an operating point so that window averages sit near the
    // thresholds; now and then a channel jumps or a sample is drawn fresh.
    task automatic queue_random_ticks(input int unsigned n);
        int unsigned v [NUM_CH];
        bit          d;
        for (int i = 0; i <= NUM_CH; i++)
            move_operating_point(i);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                move_operating_point($urandom_range(0, NUM_CH));
            for (int i = 0; i < NUM_CH; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    v[i] = (i < 3) ? volt_pick() : amp_pick();
                else
                    v[i] = jitter(op_pt[i]);
            end
            d = ($urandom_range(0, 4) == 0) ? bit'($urandom_range(0, 1)) : op_done;
            queue_tick(v[CH_BAT], v[CH_LOAD], v[CH_CHG], v[CH_BMA], v[CH_LMA], d);
        end
    endtask

    function automatic int unsigned scale_pick();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 20'hFFFFF;
            2, 3:    return 65536;
            4:       return 131072;
            default: return $urandom_range(20000, 300000);
        endcase
    endfunction

    function automatic int unsigned mv_pick(input int unsigned typ);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            default: return typ + $urandom_range(0, 1000) - 500;
        endcase
    endfunction

    task automatic retune_gauge();
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 9))
                0:       write_reg(REG_SPW, 0);
                1:       write_reg(REG_SPW, $urandom_range(5, 10));
                default: write_reg(REG_SPW, $urandom_range(1, 4));
            endcase
        end
        if ($urandom_range(0, 1))
            write_reg(REG_VOLT, scale_pick());
        if ($urandom_range(0, 1))
            write_reg(REG_AMP, scale_pick());
        if ($urandom_range(0, 1))
            write_reg(REG_BAT_MIN, mv_pick(3000));
        if ($urandom_range(0, 1))
            write_reg(REG_BAT_MAX, mv_pick(4200));
        if ($urandom_range(0, 1))
            write_reg(REG_LDO, mv_pick(3300));
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 4))
                0:       write_reg(REG_SOC_GAIN, 0);
                1:       write_reg(REG_SOC_GAIN, 20'hFFFFF);
                default: write_reg(REG_SOC_GAIN, $urandom_range(0, 65536));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       write_reg(REG_SOC_START, 0);
                1:       write_reg(REG_SOC_START, 65535);
                default: write_reg(REG_SOC_START, $urandom_range(0, 65535));
            endcase
        end
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // One tick per window and 2 mV per count so that every threshold is reachable.
        write_reg(REG_SPW, 1);
        write_reg(REG_VOLT, 131072);
        write_reg(REG_AMP, 65536);
        write_reg(REG_BAT_MIN, 3000);
        write_reg(REG_BAT_MAX, 4200);
        write_reg(REG_LDO, 3300);
        write_reg(REG_SOC_GAIN, 8192);
        write_reg(REG_SOC_START, 65535);

        // Walk the mode machine through its transitions and both calibrations.
        queue_tick(4095, 4095, 4095, 4095, 4095, 0);
        queue_tick(4095, 4095, 4095, 4095, 2048, 0);
        queue_tick(4095, 4095, 4095, 4095, 4095, 0);   // charge adds past full scale
        queue_tick(4095, 4095, 4095, 4095, 4095, 1);   // full calibration
        queue_tick(1600, 1000, 1000, 0, 0, 1);
        queue_tick(1500, 2000, 1000, 100, 100, 0);
        queue_tick(1500, 2000, 1000, 100, 100, 0);     // battery exactly at minimum
        queue_tick(1500, 1000, 1000, 0, 0, 1);
        queue_tick(1000, 1000, 2100, 300, 0, 1);
        queue_tick(1000, 1000, 2100, 300, 0, 0);
        queue_tick(1000, 1000, 1000, 0, 0, 1);
        queue_tick(2100, 1650, 2100, 0, 0, 1);
        queue_tick(2100, 1649, 2099, 0, 0, 1);
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(4095, 0, 4095, 0, 4095, 1);
        queue_tick(0, 4095, 0, 4095, 0, 0);
        drain_and_settle();

        // A window size of zero behaves as one tick.
        write_reg(REG_SPW, 0);
        write_reg(REG_SOC_START, 0);
        queue_random_ticks(8);
        drain_and_settle();

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 6)
            begin
                // Oversized window acts as the largest one; then the largest itself.
                write_reg(REG_SPW, 511);
                queue_random_ticks(200);
                drain_and_settle();
                write_reg(REG_SPW, 256);
                queue_random_ticks(56);
                drain_and_settle();
            end
            retune_gauge();
            queue_random_ticks($urandom_range(12, 30));
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/bmsf_pkg.sv
rtl/bmsf_div.sv
rtl/bmsf_mode_step.sv
rtl/battery_monitor_soc_fsm.sv
rtl/bmsf_checker.sv
tb/testbench.sv
